// ===== rtl/pfd_pkg.sv =====
`timescale 1ns / 1ps

package pfd_pkg;

  // Width of the modulus and of every operand and result value
  localparam int MODULUS_BITS = 11;
  // Signed accumulator for the Bezout coefficient during one quotient step
  localparam int COEF_ACC_BITS = 2 * MODULUS_BITS + 2;
  // Bit counter for the shift-subtract loops
  localparam int BIT_CNT_BITS = $clog2(MODULUS_BITS);
  // Depth of the queue between classifier and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(2);

  typedef struct packed {
    logic [MODULUS_BITS-1:0] dividend;
    logic [MODULUS_BITS-1:0] divisor;
  } pfd_in_t;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] quotient;
    logic                    error;
  } pfd_out_t;

  // One classified request as it waits in the queue
  typedef struct packed {
    pfd_in_t operands;
    logic    pre_err;
  } pfd_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_MUL,
    ST_DONE
  } pfd_state_t;

  // Control strobes from the engine's sequencer to its datapath
  typedef struct packed {
    logic take_job;
    logic load_res;
  } pfd_ctrl_t;

endpackage

// ===== rtl/pfd_front.sv =====
`timescale 1ns / 1ps

module pfd_front import pfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [MODULUS_BITS-1:0] modulus,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pfd_in_t                 in_data,
  output logic                    job_valid,
  input  logic                    job_ready,
  output pfd_job_t                job_data
);

  pfd_job_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt;
  logic                      push, pop;
  pfd_job_t                  job_new;

  // Flag requests that can never be answered before they reach the engine
  always_comb begin
    job_new.operands = in_data;
    job_new.pre_err  = (modulus < MODULUS_BITS'(2)) ||
                       (in_data.divisor == '0) ||
                       (in_data.divisor >= modulus) ||
                       (in_data.dividend >= modulus);
  end

  assign in_ready  = (count_r != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (count_r != '0);
  assign pop       = job_valid && job_ready;
  assign job_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_new;
    end
  end

endmodule

// ===== rtl/pfd_back.sv =====
`timescale 1ns / 1ps

module pfd_back import pfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [MODULUS_BITS-1:0] modulus,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  pfd_job_t                job_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pfd_out_t                out_data
);

  localparam int M  = MODULUS_BITS;
  localparam int TW = COEF_ACC_BITS;

  pfd_state_t state_r, state_nxt;
  pfd_ctrl_t  ctrl;

  logic [M-1:0]            c_r;
  logic [M-1:0]            r0_r, r1_r, rem_r;
  logic signed [M:0]       t0_r, t1_r;
  logic signed [TW-1:0]    tacc_r;
  logic [BIT_CNT_BITS-1:0] bit_r;
  logic                    err_r;
  logic [M-1:0]            inv_r, acc_r;
  logic                    out_valid_r;
  pfd_out_t                out_data_r;
  logic                    out_free;

  // Division step datapath
  logic [2*M-1:0]       dsub;
  logic                 ge;
  logic [M-1:0]         rem_nxt;
  logic signed [TW-1:0] t1_ext, t1_sh, tacc_nxt;

  // Coefficient fix-up and modular multiply datapath
  logic [M:0]   n_ext, t0_u, inv_add, dbl, d1, madd;
  logic [M-1:0] inv_fix, acc_nxt;

  assign out_free = !out_valid_r || out_ready;

  // Restoring division, one quotient bit a cycle; the coefficient follows
  assign dsub     = {{M{1'b0}}, r1_r} << bit_r;
  assign ge       = ({{M{1'b0}}, rem_r} >= dsub);
  assign rem_nxt  = ge ? (rem_r - dsub[M-1:0]) : rem_r;
  assign t1_ext   = {{(TW-M-1){t1_r[M]}}, t1_r};
  assign t1_sh    = t1_ext <<< bit_r;
  assign tacc_nxt = ge ? (tacc_r - t1_sh) : tacc_r;

  // Bring the final coefficient into 0..N-1
  assign n_ext   = {1'b0, modulus};
  assign t0_u    = t0_r;
  assign inv_add = t0_r[M] ? (t0_u + n_ext) : t0_u;
  assign inv_fix = (inv_add >= n_ext) ? M'(inv_add - n_ext) : inv_add[M-1:0];

  // Interleaved modular multiply, dividend bits from the top
  assign dbl     = {acc_r, 1'b0};
  assign d1      = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
  assign madd    = d1 + (c_r[bit_r] ? {1'b0, inv_r} : '0);
  assign acc_nxt = (madd >= n_ext) ? M'(madd - n_ext) : madd[M-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = job_data.pre_err ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_r == '0 && rem_nxt == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = (r0_r != M'(1)) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        if (bit_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.take_job = 1'b0;
    ctrl.load_res = 1'b0;
    case (state_r)
      ST_IDLE: ctrl.take_job = 1'b1;
      ST_DONE: ctrl.load_res = out_free;
      default: ;
    endcase
  end

  assign job_ready = ctrl.take_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_res) begin
      out_data_r.quotient <= err_r ? '0 : acc_r;
      out_data_r.error    <= err_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          c_r    <= job_data.operands.dividend;
          r0_r   <= modulus;
          r1_r   <= job_data.operands.divisor;
          rem_r  <= modulus;
          t0_r   <= '0;
          t1_r   <= (M+1)'(1);
          tacc_r <= '0;
          bit_r  <= BIT_CNT_BITS'(M - 1);
          err_r  <= job_data.pre_err;
          inv_r  <= '0;
          acc_r  <= '0;
        end
      end
      ST_DIV: begin
        if (bit_r == '0) begin
          // close the step: shift the remainder and coefficient pairs
          r0_r   <= r1_r;
          r1_r   <= rem_nxt;
          t0_r   <= t1_r;
          t1_r   <= tacc_nxt[M:0];
          rem_r  <= r1_r;
          tacc_r <= t1_ext;
          bit_r  <= BIT_CNT_BITS'(M - 1);
        end else begin
          rem_r  <= rem_nxt;
          tacc_r <= tacc_nxt;
          bit_r  <= bit_r - 1'b1;
        end
      end
      ST_FIX: begin
        if (r0_r != M'(1)) begin
          err_r <= 1'b1;
        end
        inv_r <= inv_fix;
        acc_r <= '0;
        bit_r <= BIT_CNT_BITS'(M - 1);
      end
      ST_MUL: begin
        acc_r <= acc_nxt;
        if (bit_r != '0) begin
          bit_r <= bit_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/prime_field_modular_divider_top.sv =====
`timescale 1ns / 1ps
// Flow: the queue holds each accepted request until the idle engine takes it; a request
//   flagged on entry goes straight to the done state, any other runs the Euclid steps
//   (at most 16) in the shift-subtract divider, one quotient bit a cycle, then the
//   fix-up and multiply; it takes no new request until its result is registered.
// Reset: rst_n, synchronous, active low; empties the queue and output stage
//   and sets the modulus to 2. No clearing pass.

module prime_field_modular_divider_top import pfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pfd_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pfd_out_t                out_data,
  input  logic                    cfg_we,
  input  logic [MODULUS_BITS-1:0] cfg_wdata
);

  // Modulus register; software must write it only while no request is in flight (not enforced)
  logic [MODULUS_BITS-1:0] modulus_r;

  // Queue side between classifier and engine
  logic     job_valid;
  logic     job_ready;
  pfd_job_t job_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  // Front: take each request, flag impossible ones, hold it in the queue
  pfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .modulus   (modulus_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data)
  );

  // Back: extended Euclid for the inverse, then multiply by the dividend
  // mod N; the result waits in an output register so the engine can move on
  pfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .modulus   (modulus_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
